// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

  // byte codes of the radio frame
  localparam logic [7:0] StartByte = 8'h0F;
  localparam logic [7:0] EndByte   = 8'h00;

  // frame geometry
  localparam int StoredBytes  = 23;
  localparam int DataBytes    = 22;
  localparam int DataBits     = DataBytes * 8;
  localparam int ShiftBits    = StoredBytes * 8;
  localparam int ChanWidth    = 11;
  localparam int IndexWidth   = 5;

  localparam logic [4:0] LastStored   = 5'd23;
  localparam logic [4:0] FirstDigital = 5'd16;
  localparam logic [4:0] LastChan     = 5'd17;

  localparam logic [ChanWidth-1:0] DigitalOn  = 11'd2047;
  localparam logic [ChanWidth-1:0] DigitalOff = 11'd0;

  // one checked frame waiting for the back end
  typedef struct packed {
    logic [1:0]          flags;
    logic [DataBits-1:0] data;
  } frame_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ----- sv/sfd_frame_fifo.sv -----
module sfd_frame_fifo
  import sfd_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_t        push_frame,
  input  logic          pop,
  output frame_t        head,
  output queue_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frame_t           slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  // status flags
  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("frame popped from empty queue");

endmodule

// ----- sv/sfd_front.sv -----
module sfd_front
  import sfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  logic [7:0]    rx_byte,
  input  queue_status_t status,
  output logic          push,
  output frame_t        push_frame
);

  logic                 in_frame;
  logic [4:0]           byte_position;
  logic [ShiftBits-1:0] frame_shift;
  logic                 accept;
  logic                 at_end;

  // stall only when a finished frame cannot be queued
  assign at_end     = in_frame && (byte_position == LastStored);
  assign byte_ready = !(at_end && status.full);
  assign accept     = byte_valid && byte_ready;

  // good end byte hands the frame over
  assign push             = accept && at_end && (rx_byte == EndByte);
  assign push_frame.data  = frame_shift[DataBits-1:0];
  assign push_frame.flags = frame_shift[DataBits+1:DataBits];

  // byte shifter, oldest byte ends up lowest
  always_ff @(posedge clk) begin
    if (accept && in_frame && !at_end) begin
      frame_shift <= {rx_byte, frame_shift[ShiftBits-1:8]};
    end
  end

  // sync tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        if (rx_byte == StartByte) begin
          in_frame      <= 1'b1;
          byte_position <= '0;
        end
      end else if (!at_end) begin
        byte_position <= byte_position + 1'b1;
      end else begin
        in_frame      <= 1'b0;
        byte_position <= '0;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LastStored)
    else $error("byte position past end byte");

  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> byte_position == '0)
    else $error("position not cleared while hunting");

endmodule

// ----- sv/sfd_back.sv -----
module sfd_back
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  queue_status_t         status,
  input  frame_t                head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IndexWidth-1:0] channel_index,
  output logic [ChanWidth-1:0]  channel_value,
  output logic                  last_of_frame
);

  logic                  busy;
  logic [4:0]            chan;
  logic [DataBits-1:0]   work;
  logic [1:0]            flags;
  logic                  advance;
  logic [ChanWidth-1:0]  value_next;

  // one result per cycle while the output register drains
  assign advance = busy && (!out_valid || out_ready);
  assign pop     = !status.empty && (!busy || (advance && chan == LastChan));

  // channel value select
  always_comb begin
    if (chan < FirstDigital) begin
      value_next = work[ChanWidth-1:0];
    end else if (chan == FirstDigital) begin
      value_next = flags[0] ? DigitalOn : DigitalOff;
    end else begin
      value_next = flags[1] ? DigitalOn : DigitalOff;
    end
  end

  // working frame and output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      channel_index <= chan;
      channel_value <= value_next;
      last_of_frame <= (chan == LastChan);
    end
    if (pop) begin
      work  <= head.data;
      flags <= head.flags;
    end else if (advance) begin
      work <= work >> ChanWidth;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      chan      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        chan <= '0;
      end else if (advance) begin
        chan <= chan + 1'b1;
        if (chan == LastChan) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> chan <= LastChan)
    else $error("channel counter out of range");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> channel_index == LastChan)
    else $error("frame end not on last channel");

  a_held_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_index))
    else $error("stalled result changed");

endmodule

// ----- sv/sbus_frame_decoder_unit.sv -----
// channel  dir  tdata bits                          tlast          tuser
// s_axis   in   [7:0] rx_byte                       -              -
// m_axis   out  [4:0] channel_index, [15:5] value   last_of_frame  -
//
// one byte accepted per cycle; a good frame of 25 bytes yields 18 results,
// issued one per cycle by the back end unless stalled, so results drain before
// the next frame completes. the two-frame queue decouples the byte side from
// the result side. the byte side stalls only on an end byte while the queue is
// full. synchronous active-high rst returns to hunting and drops queued frames.
module sbus_frame_decoder_unit
  import sfd_pkg::*;
#(
  parameter int FrameQueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [4:0] channel_index, [15:5] channel_value
  output logic        m_tlast    // last_of_frame
);

  queue_status_t         status;
  logic                  push;
  logic                  pop;
  frame_t                push_frame;
  frame_t                head;
  logic [IndexWidth-1:0] channel_index;
  logic [ChanWidth-1:0]  channel_value;

  // byte sync and frame capture
  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_ready (s_tready),
    .rx_byte    (s_tdata),
    .status     (status),
    .push       (push),
    .push_frame (push_frame)
  );

  // checked frames waiting for unpack
  sfd_frame_fifo #(
    .Depth (FrameQueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  // channel unpack and result register
  sfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .status        (status),
    .head          (head),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_of_frame (m_tlast)
  );

  assign m_tdata = {channel_value, channel_index};

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sfd_pkg::*;

  // one channel result as it leaves the block
  typedef struct packed {
    logic [IndexWidth-1:0] idx;
    logic [ChanWidth-1:0]  value;
    logic                  last;
  } chan_result_t;

  // how the 22 data bytes of a frame are filled
  typedef enum int {
    FillZero,
    FillOnes,
    FillStart,
    FillAlt,
    FillRandom
  } fill_mode_e;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [4:0] channel_index, [15:5] channel_value
  logic        m_tlast;    // last_of_frame

  // predictor state
  logic        frame_open;
  int unsigned stored_count;
  logic [7:0]  frame_store [StoredBytes];

  chan_result_t expected_chans [$];
  int unsigned  mismatch_count;

  // idling control
  bit tx_idle_en;
  bit rx_idle_en;
  int rx_gap;
  int rx_hold;

  sbus_frame_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // expected results for one accepted byte
  task automatic decode_rx_byte(input logic [7:0] rx);
    logic [DataBits-1:0] data_bits;
    chan_result_t        r;
    if (!frame_open) begin
      if (rx == StartByte) begin
        frame_open   = 1'b1;
        stored_count = 0;
      end
    end else if (stored_count < StoredBytes) begin
      frame_store[stored_count] = rx;
      stored_count++;
    end else begin
      // end byte: back to hunting whatever it holds
      frame_open   = 1'b0;
      stored_count = 0;
      if (rx == EndByte) begin
        for (int i = 0; i < DataBytes; i++) data_bits[i*8 +: 8] = frame_store[i];
        for (int ch = 0; ch < 16; ch++) begin
          r.idx   = IndexWidth'(ch);
          r.value = data_bits[ch*11 +: 11];
          r.last  = 1'b0;
          expected_chans.push_back(r);
        end
        r.idx   = FirstDigital;
        r.value = frame_store[StoredBytes-1][0] ? DigitalOn : DigitalOff;
        r.last  = 1'b0;
        expected_chans.push_back(r);
        r.idx   = LastChan;
        r.value = frame_store[StoredBytes-1][1] ? DigitalOn : DigitalOff;
        r.last  = 1'b1;
        expected_chans.push_back(r);
      end
    end
  endtask

  // offer one byte, wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    decode_rx_byte(b);
  endtask

  // start byte, 22 data bytes, flag byte, end byte
  task automatic send_frame(input fill_mode_e fill, input logic [7:0] flags,
                            input logic [7:0] end_byte);
    logic [7:0] d;
    send_byte(StartByte);
    for (int i = 0; i < DataBytes; i++) begin
      case (fill)
        FillZero:  d = 8'h00;
        FillOnes:  d = 8'hFF;
        FillStart: d = StartByte;
        FillAlt:   d = i[0] ? 8'hAA : 8'h55;
        default:   d = 8'($urandom);
      endcase
      send_byte(d);
    end
    send_byte(flags);
    send_byte(end_byte);
  endtask

  // receiver side: random stalls, or a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_tready <= 1'b0;
        rx_gap--;
      end else begin
        m_tready <= 1'b1;
        if (rx_idle_en) rx_gap = pick_gap();
      end
    end
  end

  function automatic void report_mismatch(input chan_result_t want, input chan_result_t got,
                                          input bit none_waiting);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (none_waiting)
        $display("%0t: unexpected result idx=%0d value=%0d last=%0b",
                 $realtime, got.idx, got.value, got.last);
      else
        $display("%0t: expected idx=%0d value=%0d last=%0b, got idx=%0d value=%0d last=%0b",
                 $realtime, want.idx, want.value, want.last, got.idx, got.value, got.last);
    end
  endfunction

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    chan_result_t got;
    chan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[4:0], m_tdata[15:5], m_tlast};
      if (expected_chans.size() == 0) begin
        report_mismatch('0, got, 1'b1);
      end else begin
        want = expected_chans.pop_front();
        if (got.idx != want.idx || got.value != want.value || got.last != want.last)
          report_mismatch(want, got, 1'b0);
      end
    end
  end

  task automatic test_reset();
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // extremes, start bytes as data, a bad end byte
  task automatic test_directed_frames();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    // noise while hunting, a zero byte is not an end byte here
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_frame(FillZero, 8'h00, EndByte);
    // upper flag bits are ignored
    send_frame(FillOnes, 8'hFF, EndByte);
    // start byte inside a frame is plain data
    send_frame(FillStart, 8'h01, EndByte);
    send_frame(FillAlt, 8'h02, EndByte);
    // start byte in the end slot drops the frame and does not restart
    send_frame(FillRandom, 8'hFC, StartByte);
    send_frame(FillRandom, 8'($urandom), EndByte);
  endtask

  // receiver holds off while frames keep coming, so the byte side must stall
  task automatic test_full_queue_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold    = 300;
    repeat (3) send_frame(FillRandom, 8'($urandom), EndByte);
    send_frame(FillOnes, 8'h00, EndByte);
  endtask

  // mostly good frames with random content, some broken ones and noise
  task automatic test_random_stream();
    int pick;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int n = 0; n < 3; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(FillRandom, 8'($urandom), EndByte);
      end else if (pick < 85) begin
        send_frame(FillRandom, 8'($urandom), 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
      // one stretch with no idling, after the first pick
      if (n == 0) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else if (n == 1) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end
    end
  endtask

  initial begin
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    frame_open     = 1'b0;
    stored_count   = 0;
    mismatch_count = 0;
    tx_idle_en     = 1'b0;
    rx_idle_en     = 1'b0;
    rx_gap         = 0;
    rx_hold        = 0;
    foreach (frame_store[i]) frame_store[i] = 8'h00;

    test_reset();
    test_directed_frames();
    test_full_queue_stall();
    test_random_stream();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_chans.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
